// ----- rtl/core/hsas_pkg.sv -----
// ----------------------------------------------------------------------------
// hsas_pkg
// Shared types, constants and helpers for the hall sector angle/speed decoder.
// ----------------------------------------------------------------------------
package hsas_pkg;

  localparam int ANGLE_BITS_DEF  = 16;
  localparam int PERIOD_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int QUOT_W      = 32;
  localparam int STEP_W      = $clog2(QUOT_W);
  localparam int ANGLE_OUT_W = 16;
  localparam int CAPTURE_W   = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int NUM_SECTORS = 6;

  // hall codes of sectors 0..5
  localparam logic [2:0] HALL_S0 = 3'h5;
  localparam logic [2:0] HALL_S1 = 3'h4;
  localparam logic [2:0] HALL_S2 = 3'h6;
  localparam logic [2:0] HALL_S3 = 3'h2;
  localparam logic [2:0] HALL_S4 = 3'h3;
  localparam logic [2:0] HALL_S5 = 3'h1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_FACTOR = 2'd0,
    CFG_SPEED_FACTOR = 2'd1,
    CFG_PHASE_SHIFT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic [2:0]           hall_code;
    logic [CAPTURE_W-1:0] capture_ticks;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_OUT_W-1:0] rotor_angle;
    logic [QUOT_W-1:0]      angle_increment;
    logic [QUOT_W-1:0]      speed_estimate;
    logic                   code_valid;
    logic                   zero_period;
  } out_item_t;

  typedef struct packed {
    logic [QUOT_W-1:0] angle_factor;
    logic [QUOT_W-1:0] speed_factor;
    logic signed [15:0] phase_shift;
  } cfg_regs_t;

  // classified event handed from front to back
  typedef struct packed {
    logic [ANGLE_OUT_W-1:0] rotor_angle;
    logic                   code_valid;
    logic                   zero_period;
    logic [CAPTURE_W-1:0]   capture;
  } job_t;

  // round(sector * 2^ab / 6), half up; elaboration time only
  function automatic logic [63:0] sector_base(input int unsigned sector,
                                              input int unsigned ab);
    logic [63:0] num;
    num = (64'(sector) << (ab + 1)) + 64'd6;
    return num / 64'd12;
  endfunction

endpackage

// ----- rtl/core/hsas_cfg.sv -----
// ----------------------------------------------------------------------------
// hsas_cfg
// Configuration register file: angle factor, speed factor, phase shift.
// ----------------------------------------------------------------------------
module hsas_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hsas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsas_pkg::CFG_DATA_W-1:0] cfg_data,
  output hsas_pkg::cfg_regs_t            cfg_regs
);
  import hsas_pkg::*;

  cfg_regs_t regs_r;

  assign cfg_ready = 1'b1;
  assign cfg_regs  = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ANGLE_FACTOR: regs_r.angle_factor <= cfg_data;
        CFG_SPEED_FACTOR: regs_r.speed_factor <= cfg_data;
        CFG_PHASE_SHIFT:  regs_r.phase_shift  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/hsas_front.sv -----
// ----------------------------------------------------------------------------
// hsas_front
// Takes hall events, maps code to sector angle with offset, keeps the held
// angle and pushes a classified job towards the divider side.
// ----------------------------------------------------------------------------
module hsas_front #(
  parameter int ANGLE_BITS  = hsas_pkg::ANGLE_BITS_DEF,
  parameter int PERIOD_BITS = hsas_pkg::PERIOD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hsas_pkg::in_item_t   in_data,
  input  hsas_pkg::cfg_regs_t  cfg_regs,
  input  logic                 queue_full,
  output logic                 push,
  output hsas_pkg::job_t       push_data
);
  import hsas_pkg::*;

  localparam logic [ANGLE_BITS-1:0] BASE [NUM_SECTORS] = '{
    ANGLE_BITS'(sector_base(0, ANGLE_BITS)),
    ANGLE_BITS'(sector_base(1, ANGLE_BITS)),
    ANGLE_BITS'(sector_base(2, ANGLE_BITS)),
    ANGLE_BITS'(sector_base(3, ANGLE_BITS)),
    ANGLE_BITS'(sector_base(4, ANGLE_BITS)),
    ANGLE_BITS'(sector_base(5, ANGLE_BITS))
  };

  logic [ANGLE_BITS-1:0]  held_angle_r, held_angle_nxt;
  logic [ANGLE_BITS-1:0]  shift_scaled;
  logic [ANGLE_BITS-1:0]  base;
  logic                   code_ok;
  logic [CAPTURE_W-1:0]   capture;

  // phase shift brought to ANGLE_BITS, modulo one turn
  if (ANGLE_BITS >= 16) begin : g_shift_up
    assign shift_scaled = ANGLE_BITS'($unsigned(cfg_regs.phase_shift)) << (ANGLE_BITS - 16);
  end else begin : g_shift_down
    assign shift_scaled = ANGLE_BITS'($unsigned(cfg_regs.phase_shift) >> (16 - ANGLE_BITS));
  end

  assign capture = in_data.capture_ticks & CAPTURE_W'((64'd1 << PERIOD_BITS) - 64'd1);

  always_comb begin
    code_ok = 1'b1;
    case (in_data.hall_code)
      HALL_S0: base = BASE[0];
      HALL_S1: base = BASE[1];
      HALL_S2: base = BASE[2];
      HALL_S3: base = BASE[3];
      HALL_S4: base = BASE[4];
      HALL_S5: base = BASE[5];
      default: begin
        base    = '0;
        code_ok = 1'b0;
      end
    endcase
  end

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    held_angle_nxt = held_angle_r;
    if (code_ok) begin
      held_angle_nxt = base + shift_scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_angle_r <= '0;
    end else if (push) begin
      held_angle_r <= held_angle_nxt;
    end
  end

  assign push_data.rotor_angle = ANGLE_OUT_W'(held_angle_nxt);
  assign push_data.code_valid  = code_ok;
  assign push_data.zero_period = (capture == '0);
  assign push_data.capture     = capture;

endmodule

// ----- rtl/core/hsas_queue.sv -----
// ----------------------------------------------------------------------------
// hsas_queue
// Small register queue between the front and the divider side.
// ----------------------------------------------------------------------------
module hsas_queue #(
  parameter int DEPTH = hsas_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hsas_pkg::job_t  push_data,
  output logic            full,
  input  logic            pop,
  output hsas_pkg::job_t  pop_data,
  output logic            empty
);
  import hsas_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointers wrap at DEPTH
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/hsas_back.sv -----
// ----------------------------------------------------------------------------
// hsas_back
// Two-lane restoring divider sharing one step counter, then the result
// register. One quotient bit per lane per cycle.
// ----------------------------------------------------------------------------
module hsas_back #(
  parameter int PERIOD_BITS = hsas_pkg::PERIOD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hsas_pkg::cfg_regs_t  cfg_regs,
  input  logic                 empty,
  input  hsas_pkg::job_t       pop_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hsas_pkg::out_item_t  out_data
);
  import hsas_pkg::*;

  localparam int PB = PERIOD_BITS;

  back_state_t             state_r, state_nxt;
  logic [STEP_W-1:0]       cnt_r, cnt_nxt;
  logic [PB-1:0]           div_r;
  logic [PB-1:0]           rem_a_r, rem_s_r;
  logic [QUOT_W-1:0]       q_a_r, q_s_r;
  logic [ANGLE_OUT_W-1:0]  angle_r;
  logic                    code_valid_r, zero_r;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r;
  logic                    load_job, div_step, load_out;
  logic [PB+QUOT_W-1:0]    step_a, step_s;

  // one restoring step: shift in next dividend bit, subtract if it fits
  function automatic logic [PB+QUOT_W-1:0] rdiv_step(input logic [PB-1:0]     rem,
                                                     input logic [QUOT_W-1:0] q,
                                                     input logic [PB-1:0]     dvs);
    logic [PB:0] part;
    logic [PB:0] trial;
    part  = {rem, q[QUOT_W-1]};
    trial = part - {1'b0, dvs};
    if (trial[PB]) begin
      return {part[PB-1:0], q[QUOT_W-2:0], 1'b0};
    end
    return {trial[PB-1:0], q[QUOT_W-2:0], 1'b1};
  endfunction

  assign step_a = rdiv_step(rem_a_r, q_a_r, div_r);
  assign step_s = rdiv_step(rem_s_r, q_s_r, div_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    load_job      = 1'b0;
    div_step      = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      BK_IDLE: begin
        if (!empty) begin
          load_job  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = pop_data.zero_period ? BK_DONE : BK_DIV;
        end
      end
      BK_DIV: begin
        div_step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(QUOT_W - 1)) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign pop = load_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_job) begin
      div_r        <= pop_data.capture[PB-1:0];
      rem_a_r      <= '0;
      rem_s_r      <= '0;
      angle_r      <= pop_data.rotor_angle;
      code_valid_r <= pop_data.code_valid;
      zero_r       <= pop_data.zero_period;
      // zero period saturates, otherwise the lanes start from the factors
      q_a_r        <= pop_data.zero_period ? '1 : cfg_regs.angle_factor;
      q_s_r        <= pop_data.zero_period ? '1 : cfg_regs.speed_factor;
    end else if (div_step) begin
      {rem_a_r, q_a_r} <= step_a;
      {rem_s_r, q_s_r} <= step_s;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.rotor_angle     <= angle_r;
      out_data_r.angle_increment <= q_a_r;
      out_data_r.speed_estimate  <= q_s_r;
      out_data_r.code_valid      <= code_valid_r;
      out_data_r.zero_period     <= zero_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/hall_sector_angle_speed_top.sv -----
// ----------------------------------------------------------------------------
// hall_sector_angle_speed_top
// Hall sensor decoder: sector angle with phase offset, angle increment and
// speed as factor / capture period.
//
//   port group | direction | handshake          | word
//   in_        | input     | in_valid/in_stall   | hall code, capture ticks
//   out_       | output    | out_valid/out_stall | angle, increment, speed, flags
//   cfg_       | input     | cfg_valid/cfg_ready | register index, write data
//
// In the back end a word goes through a load, 32 divider steps
// (both quotients in parallel, one bit each per cycle) and a result load.
// A zero capture skips the divider steps.
// The front takes a word every cycle while the two-entry queue has room.
// Synchronous active-low reset clears held angle, config, queue and control.
// cfg_ready is always high; a stalled result stays in the output register.
// ----------------------------------------------------------------------------
module hall_sector_angle_speed_top #(
  parameter int ANGLE_BITS  = hsas_pkg::ANGLE_BITS_DEF,
  parameter int PERIOD_BITS = hsas_pkg::PERIOD_BITS_DEF,
  parameter int QUEUE_DEPTH = hsas_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  hsas_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output hsas_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hsas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hsas_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hsas_pkg::*;

  cfg_regs_t cfg_regs;
  logic      push, pop, queue_full, queue_empty;
  job_t      push_data, pop_data;

  hsas_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_regs  (cfg_regs)
  );

  hsas_front #(
    .ANGLE_BITS  (ANGLE_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_regs   (cfg_regs),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  hsas_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  hsas_back #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_regs  (cfg_regs),
    .empty     (queue_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/hsas_checker.sv -----
// ----------------------------------------------------------------------------
// hsas_checker
// Port-level checks on the decoder top level, bound in below.
// ----------------------------------------------------------------------------
module hsas_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input hsas_pkg::out_item_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready
);
  import hsas_pkg::*;

  // held result word must not move while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // zero period always comes with saturated quotients
  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_period |->
      out_data.angle_increment == '1 && out_data.speed_estimate == '1)
    else $error("zero period without saturated quotients");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

  // nothing left over from before reset
  a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind hall_sector_angle_speed_top hsas_checker u_hsas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// ----- test/tb_hall_sector_angle_speed_top.sv -----
// ----------------------------------------------------------------------------
// tb_hall_sector_angle_speed_top
// Self-checking bench for the hall sector angle/speed decoder. A queue-fed
// driver offers hall edge words and predicts each result at acceptance; a
// monitor compares every result word field by field with the oldest
// prediction. Directed words cover every hall code, the invalid codes, a zero
// capture, the quotient extremes and the wrap at one turn. Random phases use
// mostly rotating code sequences under several register settings. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_hall_sector_angle_speed_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hsas_pkg::*;

  localparam int            WATCHDOG_LIMIT = 3000;
  localparam int            PRESSURE_AT    = 600;
  localparam int            PRESSURE_LEN   = 300;
  localparam int            RANDOM_PHASES  = 6;
  localparam int            PHASE_WORDS    = 265;
  localparam int            DRAIN_CYCLES   = 40;
  localparam logic [2:0]    HALL_NONE_LO   = 3'd0;
  localparam logic [2:0]    HALL_NONE_HI   = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hall_sector_angle_speed_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the registers and the held angle
  logic [31:0] angle_factor_m = '0;
  logic [31:0] speed_factor_m = '0;
  logic [15:0] phase_shift_m  = '0;
  logic [15:0] held_angle_m   = '0;

  in_item_t  pending_words[$];
  out_item_t expected_words[$];
  int        words_queued = 0;
  int        words_sent   = 0;
  int        results_seen = 0;
  int        errors       = 0;
  bit        no_idle      = 1'b0;
  int        quiet_cycles = 0;
  int        send_gap     = 0;
  int        stall_left   = 0;

  function automatic out_item_t decode_event(input in_item_t w);
    out_item_t   r;
    logic [31:0] base;
    int          sector;
    sector = -1;
    case (w.hall_code)
      HALL_S0: sector = 0;
      HALL_S1: sector = 1;
      HALL_S2: sector = 2;
      HALL_S3: sector = 3;
      HALL_S4: sector = 4;
      HALL_S5: sector = 5;
      default: sector = -1;
    endcase
    r.code_valid = (sector >= 0);
    r.zero_period = (w.capture_ticks == '0);
    if (r.zero_period) begin
      r.angle_increment = '1;
      r.speed_estimate  = '1;
    end else begin
      r.angle_increment = angle_factor_m / w.capture_ticks;
      r.speed_estimate  = speed_factor_m / w.capture_ticks;
    end
    if (r.code_valid) begin
      // sector * 2^16 / 6, rounded half up
      base = ((32'(sector) << 17) + 32'd6) / 32'd12;
      held_angle_m = base[15:0] + phase_shift_m;
    end
    r.rotor_angle = held_angle_m;
    return r;
  endfunction

  // sender: one word per handshake, random gap after each word unless no_idle is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(decode_event(in_data));
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_words.size() != 0) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
          send_gap <= no_idle ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, fname, want, got);
      errors++;
    end
  endtask

  // receiver: check each result word, then stall for a drawn number of cycles
  always @(posedge clk) begin : result_check
    out_item_t want;
    int        hold;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected result word %h", $time, out_data);
          errors++;
        end else begin
          want = expected_words.pop_front();
          check_field("rotor_angle", 32'(want.rotor_angle), 32'(out_data.rotor_angle));
          check_field("angle_increment", want.angle_increment, out_data.angle_increment);
          check_field("speed_estimate", want.speed_estimate, out_data.speed_estimate);
          check_field("code_valid", 32'(want.code_valid), 32'(out_data.code_valid));
          check_field("zero_period", 32'(want.zero_period), 32'(out_data.zero_period));
        end
        results_seen++;
        hold = no_idle ? 0 : $urandom_range(0, 3);
        // one long hold-off so the queue fills and the input stalls
        if (results_seen == PRESSURE_AT) hold = PRESSURE_LEN;
        stall_left <= hold;
        out_stall  <= (hold != 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        stall_left <= 0;
        out_stall  <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ANGLE_FACTOR: angle_factor_m = val;
      CFG_SPEED_FACTOR: speed_factor_m = val;
      CFG_PHASE_SHIFT:  phase_shift_m  = val[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_word(input logic [2:0] code, input logic [31:0] cap);
    in_item_t w;
    w.hall_code     = code;
    w.capture_ticks = cap;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (words_sent != words_queued || expected_words.size() != 0);
  endtask

  function automatic logic [2:0] sector_code(input int s);
    case (s)
      0: return HALL_S0;
      1: return HALL_S1;
      2: return HALL_S2;
      3: return HALL_S3;
      4: return HALL_S4;
      default: return HALL_S5;
    endcase
  endfunction

  function automatic logic [31:0] rand_capture();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(1, 64);
      4:       return $urandom_range(1, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_factor();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [15:0] shift;
    logic [2:0]  code;
    int          walk;
    int          pick;
    walk = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // invalid codes before any valid one give the reset angle
    write_reg(CFG_ANGLE_FACTOR, 32'hFFFF_FFFF);
    write_reg(CFG_SPEED_FACTOR, 32'd0);
    write_reg(CFG_PHASE_SHIFT, 32'h0000_7FFF);
    write_reg(CFG_UNUSED_IDX, 32'hDEAD_BEEF);
    push_word(HALL_NONE_LO, 32'd0);
    push_word(HALL_NONE_HI, 32'd1);
    push_word(HALL_S0, 32'd1);
    push_word(HALL_S1, 32'hFFFF_FFFF);
    push_word(HALL_S2, 32'd0);
    push_word(HALL_S3, 32'd2);
    push_word(HALL_S4, 32'd3);
    push_word(HALL_S5, 32'h8000_0000);
    push_word(HALL_NONE_LO, 32'd5);
    push_word(HALL_NONE_HI, 32'hFFFF_FFFF);
    wait_drained();

    // shift that puts sector 1 exactly on one turn
    write_reg(CFG_ANGLE_FACTOR, 32'd0);
    write_reg(CFG_SPEED_FACTOR, 32'hFFFF_FFFF);
    write_reg(CFG_PHASE_SHIFT, 32'hFFFF_D555);
    push_word(HALL_S1, 32'd7);
    push_word(HALL_S0, 32'd0);
    push_word(HALL_NONE_LO, 32'd1);
    push_word(HALL_S2, 32'h5555_5555);
    push_word(HALL_S3, 32'hAAAA_AAAA);
    push_word(HALL_S4, 32'd1);
    push_word(HALL_S5, 32'd0);
    push_word(HALL_NONE_HI, 32'd0);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       shift = 16'h8000;
        1:       shift = 16'h7FFF;
        2:       shift = 16'hFFFF;
        3:       shift = 16'h0000;
        default: shift = 16'($urandom);
      endcase
      no_idle = (ph == 3);
      write_reg(CFG_ANGLE_FACTOR, rand_factor());
      write_reg(CFG_SPEED_FACTOR, rand_factor());
      write_reg(CFG_PHASE_SHIFT, {16'($urandom), shift});
      if (ph == 4) write_reg(CFG_UNUSED_IDX, $urandom);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // mostly a rotor turning either way, some noise and dropouts
        pick = $urandom_range(0, 9);
        if (pick < 4) walk = (walk + 1) % 6;
        else if (pick < 7) walk = (walk + 5) % 6;
        if (pick == 8) code = $urandom_range(0, 1) ? HALL_NONE_HI : HALL_NONE_LO;
        else if (pick == 9) code = 3'($urandom_range(0, 7));
        else code = sector_code(walk);
        push_word(code, rand_capture());
      end
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $display("%0t %0d result words never arrived", $time, expected_words.size());
      errors++;
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
